[src/clw_pkg.sv]
// Package for the lighten-toward-white pixel pipeline.
// Holds the shared constants and the payload type passed between divider stages.
// No dependencies.
`default_nettype none

package clw_pkg;

    localparam logic [7:0]  CHAN_MAX  = 8'd255;
    localparam logic [16:0] FRAC_ONE  = 17'd65536;
    localparam logic [25:0] FRAC_HALF = 26'd32768;

    // Per-pixel payload through the quotient stages; index 0 is red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][16:0] rem;
        logic [2:0][7:0]  quo;
        logic [2:0][7:0]  chan;
        logic [7:0]       alpha;
        logic [8:0]       den;
    } lift_t;

endpackage

`default_nettype wire

[src/clw_div_stage.sv]
// One registered stage of the restoring divider: resolves two quotient bits per channel.
// Depends on clw_pkg (lift_t).
`default_nettype none

module clw_div_stage #(
    parameter int HI_BIT = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire clw_pkg::lift_t in_data,
    output logic               out_valid,
    output clw_pkg::lift_t     out_data
);

    localparam int LO_BIT = HI_BIT - 1;

    logic           valid_reg, valid_next;
    clw_pkg::lift_t data_reg, data_next;
    logic [16:0]    trial_hi, trial_lo;
    logic [2:0][16:0] rem_mid;

    assign trial_hi = 17'(in_data.den) << HI_BIT;
    assign trial_lo = 17'(in_data.den) << LO_BIT;

    always_comb begin
        data_next = in_data;
        for (int k = 0; k < 3; k++) begin
            rem_mid[k] = in_data.rem[k];
            if (in_data.rem[k] >= trial_hi) begin
                rem_mid[k] = in_data.rem[k] - trial_hi;
                data_next.quo[k][3'(HI_BIT)] = 1'b1;
            end
            data_next.rem[k] = rem_mid[k];
            if (rem_mid[k] >= trial_lo) begin
                data_next.rem[k] = rem_mid[k] - trial_lo;
                data_next.quo[k][3'(LO_BIT)] = 1'b1;
            end
        end
    end

    assign valid_next = en ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[src/color_lighten_toward_white.sv]
// Top level of the lighten-toward-white pixel pipeline.
// Depends on clw_pkg and clw_div_stage.
//
// Usage:
//   Pixels enter on the s_ stream (tdata = red, green, blue, alpha from bit 0 up)
//   and leave on the m_ stream in the same layout. Each colour channel is pulled
//   toward 255 in proportion to the lightening fraction; alpha is carried as is.
//   The fraction (unsigned Q1.16, values above 1.0 act as 1.0) is written on the
//   cfg channel, which is always ready; write it only while the pipeline is empty.
//   An input transfer passes through eight register stages before its result is
//   offered: min/span, fraction multiply, numerator multiply, four divider stages
//   resolving two quotient bits each, and the output register.
//   Throughput is one pixel per clock while the receiver does not stall; the rate is
//   set by the divider pipeline, every stage of which takes a new pixel each cycle.
//   Each stage has its own valid bit and advances when it is empty or the stage
//   after it moves, so bubbles close up while the receiver stalls; s_tready drops
//   only once all stages are full. A stalled result holds on m_tdata.
//   Reset (aresetn low, synchronous) empties the pipeline and clears the fraction
//   to 0, which passes pixels through unchanged.
`default_nettype none

module color_lighten_toward_white (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data,   // lighten_fraction
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // red_in, green_in, blue_in, alpha_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata     // red_out, green_out, blue_out, alpha_out
);

    // Configuration
    logic [16:0] frac_reg, frac_next;
    logic [16:0] frac_eff;

    // Stage 1: min and span
    logic        s1_v_reg, s1_v_next;
    logic [31:0] s1_pix_reg;
    logic [7:0]  s1_d_reg;
    logic [7:0]  min_rg, min_rgb;

    // Stage 2: increment of the smallest channel
    logic        s2_v_reg, s2_v_next;
    logic [31:0] s2_pix_reg;
    logic [7:0]  s2_d_reg;
    logic [7:0]  s2_inc_reg;
    logic [24:0] inc_prod;
    logic [25:0] inc_sum;
    logic [9:0]  inc_raw;
    logic [7:0]  inc_lim;

    // Stage 3: numerators and divisor
    logic           s3_v_reg, s3_v_next;
    clw_pkg::lift_t s3_reg, s3_next;
    logic [2:0][7:0]  room;
    logic [2:0][15:0] room_prod;

    // Divider stages
    logic [3:0]           dv;
    clw_pkg::lift_t [3:0] dd;
    logic [3:0]           den_stage;

    // Output stage
    logic        m_v_reg, m_v_next;
    logic [31:0] m_data_reg, m_data_next;

    logic en1, en2, en3, en8;

    // Stage enables: a stage moves when empty or when the next one moves
    assign en8          = !m_v_reg || m_tready;
    assign den_stage[3] = !dv[3] || en8;
    assign den_stage[2] = !dv[2] || den_stage[3];
    assign den_stage[1] = !dv[1] || den_stage[2];
    assign den_stage[0] = !dv[0] || den_stage[1];
    assign en3          = !s3_v_reg || den_stage[0];
    assign en2          = !s2_v_reg || en3;
    assign en1          = !s1_v_reg || en2;
    assign s_tready     = en1;

    assign cfg_ready = 1'b1;
    assign frac_next = cfg_valid ? cfg_data : frac_reg;
    assign frac_eff  = frac_reg[16] ? clw_pkg::FRAC_ONE : frac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg <= 17'd0;
        end else begin
            frac_reg <= frac_next;
        end
    end

    // Stage 1
    assign min_rg    = (s_tdata[15:8] < s_tdata[7:0]) ? s_tdata[15:8] : s_tdata[7:0];
    assign min_rgb   = (s_tdata[23:16] < min_rg) ? s_tdata[23:16] : min_rg;
    assign s1_v_next = en1 ? s_tvalid : s1_v_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_pix_reg <= s_tdata;
            s1_d_reg   <= clw_pkg::CHAN_MAX - min_rgb;
        end
    end

    // Stage 2: inc = round(d * f), capped at d
    assign inc_prod  = 25'(s1_d_reg) * 25'(frac_eff);
    assign inc_sum   = 26'(inc_prod) + clw_pkg::FRAC_HALF;
    assign inc_raw   = inc_sum[25:16];
    assign inc_lim   = (inc_raw > 10'(s1_d_reg)) ? s1_d_reg : inc_raw[7:0];
    assign s2_v_next = en2 ? s1_v_reg : s2_v_reg;

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_pix_reg <= s1_pix_reg;
            s2_d_reg   <= s1_d_reg;
            s2_inc_reg <= inc_lim;
        end
    end

    // Stage 3: numerator 2*room*inc + d over divisor 2*d.
    // A white pixel has d = 0 and a zero numerator; divisor 1 gives a zero quotient.
    always_comb begin
        s3_next.alpha = s2_pix_reg[31:24];
        s3_next.den   = (s2_d_reg == 8'd0) ? 9'd1 : {s2_d_reg, 1'b0};
        for (int k = 0; k < 3; k++) begin
            room[k]         = clw_pkg::CHAN_MAX - s2_pix_reg[8*k +: 8];
            room_prod[k]    = 16'(room[k]) * 16'(s2_inc_reg);
            s3_next.chan[k] = s2_pix_reg[8*k +: 8];
            s3_next.quo[k]  = 8'd0;
            s3_next.rem[k]  = {room_prod[k], 1'b0} + 17'(s2_d_reg);
        end
    end

    assign s3_v_next = en3 ? s2_v_reg : s3_v_reg;

    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_reg <= s3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            m_v_reg  <= 1'b0;
        end else begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
            s3_v_reg <= s3_v_next;
            m_v_reg  <= m_v_next;
        end
    end

    // Quotient bits 7..0, two per stage
    clw_div_stage #(.HI_BIT(7)) u_div0 (
        .aclk(aclk), .aresetn(aresetn), .en(den_stage[0]),
        .in_valid(s3_v_reg), .in_data(s3_reg),
        .out_valid(dv[0]), .out_data(dd[0])
    );

    clw_div_stage #(.HI_BIT(5)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .en(den_stage[1]),
        .in_valid(dv[0]), .in_data(dd[0]),
        .out_valid(dv[1]), .out_data(dd[1])
    );

    clw_div_stage #(.HI_BIT(3)) u_div2 (
        .aclk(aclk), .aresetn(aresetn), .en(den_stage[2]),
        .in_valid(dv[1]), .in_data(dd[1]),
        .out_valid(dv[2]), .out_data(dd[2])
    );

    clw_div_stage #(.HI_BIT(1)) u_div3 (
        .aclk(aclk), .aresetn(aresetn), .en(den_stage[3]),
        .in_valid(dv[2]), .in_data(dd[2]),
        .out_valid(dv[3]), .out_data(dd[3])
    );

    // Output register: channel plus rounded lift, never above 255
    always_comb begin
        m_data_next[31:24] = dd[3].alpha;
        for (int k = 0; k < 3; k++) begin
            m_data_next[8*k +: 8] = dd[3].chan[k] + dd[3].quo[k];
        end
    end

    assign m_v_next = en8 ? dv[3] : m_v_reg;

    always_ff @(posedge aclk) begin
        if (en8) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[src/clw_checker.sv]
// Port-level checks for the lighten-toward-white pipeline, bound to the top level.
// Depends on color_lighten_toward_white's port list only.
`default_nettype none

module clw_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result stays offered and unchanged
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped during stall");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A moving output means every stage can move, so the input is ready
    a_ready_when_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // With the output empty there is room somewhere in the pipeline
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind color_lighten_toward_white clw_checker u_clw_checker (.*);

`default_nettype wire

[bench/tb_color_lighten_toward_white.sv]
// Self-checking bench for color_lighten_toward_white: random and directed RGBA pixels
// under several lightening fractions, results scored against an in-bench predictor.
// Depends on clw_pkg and the color_lighten_toward_white RTL.
`default_nettype none

module tb_color_lighten_toward_white;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SEGMENTS     = 8;
    localparam int SEG_PIXELS   = 200;

    // red in the lowest byte, as on the stream
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef struct {
        bit          is_cfg;
        logic [16:0] frac;
        pixel_t      pix;
    } job_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // red, green, blue, alpha
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // red, green, blue, alpha

    job_t        jobs[$];
    pixel_t      lit_q[$];
    logic [16:0] fraction_now = '0;
    int          pix_in    = 0;
    int          pix_total = 0;
    int          n_errors  = 0;
    int          cycles    = 0;
    bit          pix_taken = 1'b0;
    bit          cfg_taken = 1'b0;

    color_lighten_toward_white uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic pixel_t lighten_toward_white(pixel_t p, logic [16:0] frac);
        int unsigned chans[3];
        int unsigned lo, span, f, inc;
        pixel_t      q;
        q        = p;
        chans[0] = p.red;
        chans[1] = p.green;
        chans[2] = p.blue;
        lo = chans[0];
        if (chans[1] < lo) lo = chans[1];
        if (chans[2] < lo) lo = chans[2];
        if (lo != clw_pkg::CHAN_MAX) begin
            f    = (frac > clw_pkg::FRAC_ONE) ? clw_pkg::FRAC_ONE : frac;
            span = clw_pkg::CHAN_MAX - lo;
            inc  = (span * f + clw_pkg::FRAC_HALF) >> 16;
            if (inc > span) inc = span;
            for (int i = 0; i < 3; i++) begin
                chans[i] += ((clw_pkg::CHAN_MAX - chans[i]) * inc * 2 + span) / (2 * span);
            end
            q.red   = 8'(chans[0]);
            q.green = 8'(chans[1]);
            q.blue  = 8'(chans[2]);
        end
        return q;
    endfunction

    task automatic check_pixel(pixel_t got);
        pixel_t want;
        string  names[4] = '{"red", "green", "blue", "alpha"};
        if (lit_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected pixel, expected none, got %h", $time, got);
        end else begin
            want = lit_q.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (want[i*8 +: 8] !== got[i*8 +: 8]) begin
                    n_errors++;
                    $display("%0t: %s expected %0d got %0d", $time, names[i],
                             want[i*8 +: 8], got[i*8 +: 8]);
                end
            end
        end
    endtask

    task automatic add_cfg(logic [16:0] v);
        job_t j;
        j.is_cfg = 1'b1;
        j.frac   = v;
        j.pix    = '0;
        jobs.push_back(j);
    endtask

    task automatic add_rgba(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        job_t j;
        j.is_cfg    = 1'b0;
        j.frac      = '0;
        j.pix.red   = r;
        j.pix.green = g;
        j.pix.blue  = b;
        j.pix.alpha = a;
        jobs.push_back(j);
        pix_total++;
    endtask

    // sample on the rising edge: record transfers and score results
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                fraction_now = cfg_data;
                cfg_taken    = 1'b1;
            end
            if (s_tvalid && s_tready) begin
                lit_q.push_back(lighten_toward_white(s_tdata, fraction_now));
                pix_in++;
                pix_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
                check_pixel(m_tdata);
        end
    end

    // drive on the falling edge; config writes wait for an empty pipeline
    always @(negedge aclk) begin : drive
        bit   pix_busy, cfg_busy, drive_pix, drive_cfg;
        int   send_idle, recv_idle;
        job_t nxt;
        if (pix_in < pix_total / 3) begin
            send_idle = 17;
            recv_idle = 85;
        end else if (pix_in < 2 * pix_total / 3) begin
            send_idle = 85;
            recv_idle = 17;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        pix_busy  = s_tvalid && !pix_taken;
        cfg_busy  = cfg_valid && !cfg_taken;
        pix_taken = 1'b0;
        cfg_taken = 1'b0;
        drive_pix = pix_busy;
        drive_cfg = cfg_busy;
        if (aresetn && !pix_busy && !cfg_busy && jobs.size() > 0) begin
            if (jobs[0].is_cfg) begin
                if (lit_q.size() == 0) begin
                    nxt       = jobs.pop_front();
                    drive_cfg = 1'b1;
                    cfg_data <= nxt.frac;
                end
            end else if ($urandom_range(99) >= send_idle) begin
                nxt       = jobs.pop_front();
                drive_pix = 1'b1;
                s_tdata  <= nxt.pix;
            end
        end
        s_tvalid  <= drive_pix;
        cfg_valid <= drive_cfg;
        m_tready  <= aresetn ? ($urandom_range(99) >= recv_idle) : 1'b0;
    end

    initial begin : stimulus
        logic [16:0] seg_frac[SEGMENTS];
        logic [7:0]  r, g, b, lvl;
        int          kind;

        // directed: pass-through at zero, full white, saturated fractions, all-white pixels
        add_cfg(17'd0);
        add_rgba(8'd0, 8'd0, 8'd0, 8'd0);
        add_rgba(8'd255, 8'd255, 8'd255, 8'd255);
        add_rgba(8'd12, 8'd200, 8'd77, 8'h5A);
        add_cfg(17'd65536);
        add_rgba(8'd0, 8'd0, 8'd0, 8'd255);
        add_rgba(8'd254, 8'd255, 8'd255, 8'hA5);
        add_rgba(8'd100, 8'd50, 8'd200, 8'd7);
        add_rgba(8'd255, 8'd255, 8'd255, 8'd0);
        add_cfg(17'd131071);
        add_rgba(8'd0, 8'd128, 8'd255, 8'h3C);
        add_rgba(8'd254, 8'd254, 8'd254, 8'hC3);
        add_cfg(17'd65537);
        add_rgba(8'd1, 8'd2, 8'd3, 8'd4);
        add_cfg(17'd32768);
        add_rgba(8'd0, 8'd255, 8'd255, 8'd1);
        add_rgba(8'd255, 8'd0, 8'd255, 8'd2);
        add_rgba(8'd255, 8'd255, 8'd0, 8'd3);
        add_rgba(8'd128, 8'd128, 8'd128, 8'h80);
        add_rgba(8'd254, 8'd0, 8'd127, 8'hFF);
        add_cfg(17'd1);
        add_rgba(8'd0, 8'd0, 8'd0, 8'h11);
        add_rgba(8'd200, 8'd201, 8'd202, 8'h22);
        add_cfg(17'd65535);
        add_rgba(8'd0, 8'd0, 8'd0, 8'h33);
        add_rgba(8'd0, 8'd100, 8'd255, 8'h44);

        seg_frac[0] = 17'($urandom_range(65536));
        seg_frac[1] = 17'd65536;
        seg_frac[2] = 17'($urandom_range(131071, 65537));
        seg_frac[3] = 17'd0;
        seg_frac[4] = 17'($urandom_range(131071));
        seg_frac[5] = 17'($urandom_range(65536));
        seg_frac[6] = 17'd1;
        seg_frac[7] = 17'd131071;

        for (int s = 0; s < SEGMENTS; s++) begin
            add_cfg(seg_frac[s]);
            for (int k = 0; k < SEG_PIXELS; k++) begin
                kind = $urandom_range(9);
                if (kind == 0) begin
                    r = 8'd255;
                    g = 8'd255;
                    b = 8'd255;
                end else if (kind <= 2) begin
                    // close to white, where the span is tiny
                    r = 8'($urandom_range(255, 240));
                    g = 8'($urandom_range(255, 240));
                    b = 8'($urandom_range(255, 240));
                end else if (kind == 3) begin
                    lvl = 8'($urandom_range(255));
                    r = lvl;
                    g = lvl;
                    b = lvl;
                end else begin
                    r = 8'($urandom_range(255));
                    g = 8'($urandom_range(255));
                    b = 8'($urandom_range(255));
                end
                add_rgba(r, g, b, 8'($urandom_range(255)));
            end
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (jobs.size() != 0 || s_tvalid || cfg_valid || lit_q.size() != 0);
        repeat (PIPE_LATENCY * 4) @(posedge aclk);

        if (n_errors == 0 && lit_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/clw_pkg.sv
src/clw_div_stage.sv
src/color_lighten_toward_white.sv
src/clw_checker.sv
bench/tb_color_lighten_toward_white.sv
